>>> rtl/cfdd_pkg.sv
`default_nettype none

package cfdd_pkg;

	localparam int VALUE_DEPTH = 32;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TERM = 1'b1;

	localparam logic [7:0] PREFIX_RESET = 8'd38;
	localparam logic [7:0] TERM_RESET = 8'd37;

	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF = 8'h0a;
	localparam logic [7:0] CHAR_CR = 8'h0d;

	localparam int MSGQ_DEPTH = 4;
	localparam int MSGQ_AW = $clog2(MSGQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW = $clog2(OUTQ_DEPTH);

	typedef enum logic [3:0] {
		MODE_HUNT    = 4'b0001,
		MODE_PREFIX1 = 4'b0010,
		MODE_FRAME   = 4'b0100,
		MODE_LEGACY  = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [7:0] cmd;
		logic       legacy;
		logic       hasval;
	} msg_hdr_t;

	typedef struct packed {
		logic [7:0] cmd;
		logic       legacy;
		logic       hasval;
		logic       cv;
		logic [7:0] value;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/cfdd_parser.sv
`default_nettype none

module cfdd_parser #(
	parameter int VALUE_DEPTH = cfdd_pkg::VALUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [cfdd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cfdd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             push,
	input  wire logic [7:0]                       rx_byte,
	output logic                                  full,
	input  wire logic [$clog2(VALUE_DEPTH)+1:0]   ring_rd_ptr,
	output logic                                  mem_we,
	output logic [$clog2(VALUE_DEPTH):0]          mem_addr,
	output logic [7:0]                            mem_data,
	output logic                                  msg_push,
	output cfdd_pkg::msg_hdr_t                    msg_hdr,
	output logic [$clog2(VALUE_DEPTH+1)-1:0]      msg_count,
	input  wire logic                             msg_full
);

	localparam int CW = $clog2(VALUE_DEPTH + 1);
	localparam int RA = $clog2(VALUE_DEPTH) + 1;
	localparam int PW = RA + 1;
	localparam int RING = 1 << RA;

	typedef struct packed {
		logic          have;
		logic          sdone;
		logic          sp;
		logic [CW-1:0] cnt;
		logic [7:0]    cmd;
		logic          st;
		logic          ok;
	} body_t;

	function automatic body_t body_byte(body_t s, logic [7:0] c);
		body_t r;
		r = s;
		r.st = 1'b0;
		r.ok = 1'b1;
		if (!(c inside {cfdd_pkg::CHAR_CR, cfdd_pkg::CHAR_LF})) begin
			if (!s.have) begin
				r.cmd = c;
				r.have = 1'b1;
			end else if (!s.sdone) begin
				r.sdone = 1'b1;
				r.sp = (c == cfdd_pkg::CHAR_SP);
			end else if (s.sp) begin
				if (s.cnt >= CW'(VALUE_DEPTH)) begin
					r.ok = 1'b0;
				end else begin
					r.st = 1'b1;
					r.cnt = s.cnt + 1'b1;
				end
			end
		end
		return r;
	endfunction

	cfdd_pkg::mode_t mode_q, mode_d;
	logic            held_q, held_d;
	logic            have_q, sdone_q, sp_q;
	logic [CW-1:0]   cnt_q;
	logic [7:0]      cmd_q;
	logic [PW-1:0]   base_q, base_d;
	logic [7:0]      pre_q, term_q;
	logic            pend_v_q, pend_v_d;
	logic [RA-1:0]   pend_a_q, pend_a_d;
	logic [7:0]      pend_d_q, pend_d_d;

	body_t           cur, nxt, sec, r1, r2;
	logic            accept, is_ws, hunt, emit, emit_leg, emit_hv, lg_go, fr_go;
	logic [CW-1:0]   emit_n;
	logic [PW-1:0]   addr_cur, addr_sec, used;
	logic            w0v, w1v;
	logic [RA-1:0]   w0a, w1a;
	logic [7:0]      w0d, w1d;

	assign addr_cur = base_q + PW'(cnt_q);
	assign used = addr_cur - ring_rd_ptr;
	assign full = (used >= PW'(RING - 1)) || msg_full;
	assign accept = push && !full;
	assign is_ws = rx_byte inside {cfdd_pkg::CHAR_SP, cfdd_pkg::CHAR_TAB,
		cfdd_pkg::CHAR_CR, cfdd_pkg::CHAR_LF};

	always_comb begin
		cur = {have_q, sdone_q, sp_q, cnt_q, cmd_q, 1'b0, 1'b1};
		nxt = cur;
		sec = cur;
		r1 = cur;
		r2 = cur;
		mode_d = mode_q;
		held_d = held_q;
		hunt = 1'b0;
		emit = 1'b0;
		emit_leg = 1'b0;
		emit_hv = 1'b0;
		lg_go = 1'b0;
		fr_go = 1'b0;
		w0v = 1'b0;
		w1v = 1'b0;
		w0d = term_q;
		w1d = rx_byte;
		if (accept) begin
			case (mode_q)
				cfdd_pkg::MODE_HUNT: begin
					if (!is_ws) begin
						nxt.cnt = '0;
						nxt.sdone = 1'b0;
						nxt.sp = 1'b0;
						held_d = 1'b0;
						if (rx_byte == pre_q) begin
							mode_d = cfdd_pkg::MODE_PREFIX1;
							nxt.have = 1'b0;
						end else begin
							mode_d = cfdd_pkg::MODE_LEGACY;
							nxt.cmd = rx_byte;
							nxt.have = 1'b1;
						end
					end
				end
				cfdd_pkg::MODE_PREFIX1: begin
					if (rx_byte == pre_q) begin
						if (pre_q == term_q) begin
							hunt = 1'b1;
						end else begin
							mode_d = cfdd_pkg::MODE_FRAME;
							nxt.have = 1'b0;
						end
					end else begin
						mode_d = cfdd_pkg::MODE_LEGACY;
						sec.cmd = pre_q;
						sec.have = 1'b1;
						nxt = sec;
						lg_go = 1'b1;
					end
				end
				cfdd_pkg::MODE_LEGACY: begin
					lg_go = 1'b1;
				end
				cfdd_pkg::MODE_FRAME: begin
					if (!held_q) begin
						fr_go = 1'b1;
					end else if (rx_byte == term_q) begin
						emit = have_q;
						emit_hv = sdone_q && sp_q;
						hunt = 1'b1;
					end else begin
						r1 = body_byte(cur, term_q);
						if (!r1.ok) begin
							hunt = 1'b1;
						end else begin
							held_d = 1'b0;
							w0v = r1.st;
							sec = r1;
							nxt = r1;
							fr_go = 1'b1;
						end
					end
				end
				default: begin
					hunt = 1'b1;
				end
			endcase
			if (lg_go) begin
				if (rx_byte == cfdd_pkg::CHAR_LF) begin
					emit = sec.sdone && sec.sp && (sec.cnt != '0);
					emit_leg = 1'b1;
					emit_hv = 1'b1;
					hunt = 1'b1;
				end else begin
					r2 = body_byte(sec, rx_byte);
					if (!r2.ok) begin
						hunt = 1'b1;
					end else begin
						nxt = r2;
						w1v = r2.st;
					end
				end
			end
			if (fr_go) begin
				if (rx_byte == term_q) begin
					nxt = sec;
					held_d = 1'b1;
				end else begin
					r2 = body_byte(sec, rx_byte);
					if (!r2.ok) begin
						hunt = 1'b1;
					end else begin
						nxt = r2;
						w1v = r2.st;
					end
				end
			end
			if (hunt) begin
				mode_d = cfdd_pkg::MODE_HUNT;
				held_d = 1'b0;
				nxt.have = 1'b0;
				nxt.sdone = 1'b0;
				nxt.sp = 1'b0;
				nxt.cnt = '0;
				w0v = 1'b0;
				w1v = 1'b0;
			end
		end
		addr_sec = base_q + PW'(sec.cnt);
		w0a = addr_cur[RA-1:0];
		w1a = addr_sec[RA-1:0];
		emit_n = emit_hv ? sec.cnt : '0;
		base_d = emit ? (base_q + PW'(emit_n)) : base_q;
	end

	// one store write a cycle; a second byte waits in the pending slot
	always_comb begin
		mem_we = pend_v_q || w0v || w1v;
		if (pend_v_q) begin
			mem_addr = pend_a_q;
			mem_data = pend_d_q;
		end else if (w0v) begin
			mem_addr = w0a;
			mem_data = w0d;
		end else begin
			mem_addr = w1a;
			mem_data = w1d;
		end
		pend_v_d = pend_v_q ? (w0v || w1v) : (w0v && w1v);
		if (pend_v_q && w0v) begin
			pend_a_d = w0a;
			pend_d_d = w0d;
		end else begin
			pend_a_d = w1a;
			pend_d_d = w1d;
		end
	end

	assign msg_push = emit;
	assign msg_hdr = '{cmd: sec.cmd, legacy: emit_leg, hasval: emit_hv};
	assign msg_count = emit_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cfdd_pkg::MODE_HUNT;
			held_q <= 1'b0;
			have_q <= 1'b0;
			sdone_q <= 1'b0;
			sp_q <= 1'b0;
			cnt_q <= '0;
			cmd_q <= '0;
			base_q <= '0;
			pend_v_q <= 1'b0;
			pre_q <= cfdd_pkg::PREFIX_RESET;
			term_q <= cfdd_pkg::TERM_RESET;
		end else begin
			mode_q <= mode_d;
			held_q <= held_d;
			have_q <= nxt.have;
			sdone_q <= nxt.sdone;
			sp_q <= nxt.sp;
			cnt_q <= nxt.cnt;
			cmd_q <= nxt.cmd;
			base_q <= base_d;
			pend_v_q <= pend_v_d;
			if (cfg_write) begin
				case (cfg_index)
					cfdd_pkg::REG_PREFIX: pre_q <= cfg_data;
					cfdd_pkg::REG_TERM: term_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_a_q <= pend_a_d;
		pend_d_q <= pend_d_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VALUE_DEPTH))
		else $error("value count past depth");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= PW'(RING))
		else $error("value ring overrun");

	a_held_frame: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> mode_q == cfdd_pkg::MODE_FRAME)
		else $error("held terminator outside frame");

	a_emit_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		msg_push |=> mode_q == cfdd_pkg::MODE_HUNT)
		else $error("no return to hunting after message");

endmodule

`default_nettype wire

>>> rtl/cfdd_msg_fifo.sv
`default_nettype none

module cfdd_msg_fifo #(
	parameter int CW = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  cfdd_pkg::msg_hdr_t      push_hdr,
	input  wire logic [CW-1:0]      push_count,
	output logic                    full,
	input  wire logic               pop,
	output logic                    empty,
	output cfdd_pkg::msg_hdr_t      head_hdr,
	output logic [CW-1:0]           head_count
);

	localparam int AW = cfdd_pkg::MSGQ_AW;

	cfdd_pkg::msg_hdr_t hdr_q [cfdd_pkg::MSGQ_DEPTH];
	logic [CW-1:0]      count_q [cfdd_pkg::MSGQ_DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [AW:0]        occ_q;
	logic               do_push, do_pop;

	assign full = (occ_q == (AW+1)'(cfdd_pkg::MSGQ_DEPTH));
	assign empty = (occ_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_hdr = hdr_q[rd_q];
	assign head_count = count_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			occ_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			occ_q <= occ_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			hdr_q[wr_q] <= push_hdr;
			count_q[wr_q] <= push_count;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= (AW+1)'(cfdd_pkg::MSGQ_DEPTH))
		else $error("message queue occupancy out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("message pushed into full queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == (AW+1)'(cfdd_pkg::MSGQ_DEPTH)) |-> wr_q == rd_q)
		else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

>>> rtl/cfdd_emitter.sv
`default_nettype none

module cfdd_emitter #(
	parameter int VALUE_DEPTH = cfdd_pkg::VALUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             mem_we,
	input  wire logic [$clog2(VALUE_DEPTH):0]     mem_addr,
	input  wire logic [7:0]                       mem_data,
	output logic [$clog2(VALUE_DEPTH)+1:0]        ring_rd_ptr,
	input  wire logic                             msg_empty,
	input  cfdd_pkg::msg_hdr_t                    msg_hdr,
	input  wire logic [$clog2(VALUE_DEPTH+1)-1:0] msg_count,
	output logic                                  msg_pop,
	output logic                                  empty,
	input  wire logic                             pop,
	output cfdd_pkg::result_t                     head
);

	localparam int CW = $clog2(VALUE_DEPTH + 1);
	localparam int RA = $clog2(VALUE_DEPTH) + 1;
	localparam int PW = RA + 1;
	localparam int RING = 1 << RA;
	localparam int OAW = cfdd_pkg::OUTQ_AW;

	logic [7:0]         mem [RING];

	logic               active_q;
	logic               none_q;
	cfdd_pkg::msg_hdr_t hdr_q;
	logic [CW-1:0]      rem_q;
	logic [PW-1:0]      rd_ptr_q;

	logic               v_s1;
	cfdd_pkg::msg_hdr_t hdr_s1;
	logic               cv_s1;
	logic               last_s1;
	logic [7:0]         rdata_s1;

	cfdd_pkg::result_t  oq_q [cfdd_pkg::OUTQ_DEPTH];
	logic [OAW-1:0]     oq_wr_q, oq_rd_q;
	logic [OAW:0]       occ_q;

	logic               issue, is_last, rd_en, do_pop;
	cfdd_pkg::result_t  oq_in;

	assign issue = active_q && ((occ_q + (OAW+1)'(v_s1)) < (OAW+1)'(cfdd_pkg::OUTQ_DEPTH));
	assign is_last = none_q || (rem_q == CW'(1));
	assign rd_en = issue && !none_q;
	assign msg_pop = !active_q && !msg_empty;
	assign ring_rd_ptr = rd_ptr_q;
	assign empty = (occ_q == '0);
	assign do_pop = pop && !empty;
	assign head = oq_q[oq_rd_q];

	always_comb begin
		oq_in.cmd = hdr_s1.cmd;
		oq_in.legacy = hdr_s1.legacy;
		oq_in.hasval = hdr_s1.hasval;
		oq_in.cv = cv_s1;
		oq_in.value = cv_s1 ? rdata_s1 : 8'h00;
		oq_in.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rd_ptr_q <= '0;
			v_s1 <= 1'b0;
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			occ_q <= '0;
		end else begin
			if (msg_pop) begin
				active_q <= 1'b1;
			end else if (issue && is_last) begin
				active_q <= 1'b0;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			v_s1 <= issue;
			if (v_s1) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (do_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			occ_q <= occ_q + (OAW+1)'(v_s1) - (OAW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (msg_pop) begin
			hdr_q <= msg_hdr;
			rem_q <= msg_count;
			none_q <= (msg_count == '0);
		end else if (rd_en) begin
			rem_q <= rem_q - 1'b1;
		end
		if (issue) begin
			hdr_s1 <= hdr_q;
			cv_s1 <= !none_q;
			last_s1 <= is_last;
		end
		if (v_s1) begin
			oq_q[oq_wr_q] <= oq_in;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_ptr_q[RA-1:0]];
		end
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= (OAW+1)'(cfdd_pkg::OUTQ_DEPTH))
		else $error("result queue overrun");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && rd_en) |-> mem_addr != rd_ptr_q[RA-1:0])
		else $error("value read of a slot being written");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !none_q) |-> rem_q != '0)
		else $error("active run with no bytes left");

endmodule

`default_nettype wire

>>> rtl/command_frame_deframer_unit.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           rx_byte[7:0]
// result    out        empty / pop           command_char, is_legacy, has_value,
//                                            char_valid, value_char, last
// config    in         cfg_write (no wait)   cfg_index, cfg_data[7:0]
//
// The parser takes one byte per cycle; full rises only when the value ring or the
// message queue has no room, and stays high until the emitter frees room in them.
// The emitter gives one result per cycle while the output queue has room, and
// pauses to open each message; its rate is set by the value ring's single read port.
// Results sit in a four-entry output queue, so input and output stall independently.
// Reset clears parser, queues and emitter at once; the value ring needs no clearing.
`default_nettype none

module command_frame_deframer_unit #(
	parameter int VALUE_DEPTH = cfdd_pkg::VALUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [cfdd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cfdd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      rx_byte,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic [7:0]                           command_char,
	output logic                                 is_legacy,
	output logic                                 has_value,
	output logic                                 char_valid,
	output logic [7:0]                           value_char,
	output logic                                 last
);

	localparam int CW = $clog2(VALUE_DEPTH + 1);
	localparam int RA = $clog2(VALUE_DEPTH) + 1;
	localparam int PW = RA + 1;

	logic               mem_we;
	logic [RA-1:0]      mem_addr;
	logic [7:0]         mem_data;
	logic [PW-1:0]      ring_rd_ptr;
	logic               mq_push, mq_full, mq_pop, mq_empty;
	cfdd_pkg::msg_hdr_t mq_in_hdr, mq_head_hdr;
	logic [CW-1:0]      mq_in_count, mq_head_count;
	cfdd_pkg::result_t  head;

	cfdd_parser #(
		.VALUE_DEPTH(VALUE_DEPTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.rx_byte(rx_byte),
		.full(full),
		.ring_rd_ptr(ring_rd_ptr),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_data(mem_data),
		.msg_push(mq_push),
		.msg_hdr(mq_in_hdr),
		.msg_count(mq_in_count),
		.msg_full(mq_full)
	);

	cfdd_msg_fifo #(
		.CW(CW)
	) u_msg_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(mq_push),
		.push_hdr(mq_in_hdr),
		.push_count(mq_in_count),
		.full(mq_full),
		.pop(mq_pop),
		.empty(mq_empty),
		.head_hdr(mq_head_hdr),
		.head_count(mq_head_count)
	);

	cfdd_emitter #(
		.VALUE_DEPTH(VALUE_DEPTH)
	) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_data(mem_data),
		.ring_rd_ptr(ring_rd_ptr),
		.msg_empty(mq_empty),
		.msg_hdr(mq_head_hdr),
		.msg_count(mq_head_count),
		.msg_pop(mq_pop),
		.empty(empty),
		.pop(pop),
		.head(head)
	);

	assign command_char = head.cmd;
	assign is_legacy = head.legacy;
	assign has_value = head.hasval;
	assign char_valid = head.cv;
	assign value_char = head.value;
	assign last = head.last;

endmodule

`default_nettype wire

>>> dv/tb_command_frame_deframer_unit.sv
`timescale 1ns / 100ps

module tb_command_frame_deframer_unit;

	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int IDLE_PCT = 22;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_write;
	logic [cfdd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cfdd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            push;
	logic                            full;
	logic [7:0]                      rx_byte;
	logic                            empty;
	logic                            pop = 1'b0;
	logic [7:0]                      command_char;
	logic                            is_legacy;
	logic                            has_value;
	logic                            char_valid;
	logic [7:0]                      value_char;
	logic                            last;

	command_frame_deframer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.command_char (command_char),
		.is_legacy    (is_legacy),
		.has_value    (has_value),
		.char_valid   (char_valid),
		.value_char   (value_char),
		.last         (last)
	);

	// deframer state mirror
	cfdd_pkg::mode_t parse_state;
	logic [7:0]      prefix_q;
	logic [7:0]      term_q;
	bit              term_held;
	int              value_count;
	logic [7:0]      cmd_q;
	bit              space_after_cmd;
	bit              cmd_seen;
	bit              second_seen;
	logic [7:0]      value_buf [cfdd_pkg::VALUE_DEPTH];

	cfdd_pkg::result_t pending_results [$];
	cfdd_pkg::result_t want;

	bit stall_en;
	int errors;
	int bytes_sent;
	int results_seen;
	int settings_used;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void go_hunting();
		parse_state = cfdd_pkg::MODE_HUNT;
		term_held = 1'b0;
		value_count = 0;
		cmd_seen = 1'b0;
		second_seen = 1'b0;
		space_after_cmd = 1'b0;
	endfunction

	function automatic void reset_model();
		prefix_q = cfdd_pkg::PREFIX_RESET;
		term_q = cfdd_pkg::TERM_RESET;
		cmd_q = 8'h00;
		go_hunting();
	endfunction

	function automatic bit store_body(input logic [7:0] c);
		if (c inside {cfdd_pkg::CHAR_CR, cfdd_pkg::CHAR_LF})
			return 1'b1;
		if (!cmd_seen) begin
			cmd_q = c;
			cmd_seen = 1'b1;
		end else if (!second_seen) begin
			second_seen = 1'b1;
			space_after_cmd = (c == cfdd_pkg::CHAR_SP);
		end else if (space_after_cmd) begin
			if (value_count >= cfdd_pkg::VALUE_DEPTH)
				return 1'b0;
			value_buf[value_count] = c;
			value_count++;
		end
		return 1'b1;
	endfunction

	function automatic void queue_message(input bit legacy, input bit hasval);
		cfdd_pkg::result_t r;
		int n;
		n = hasval ? value_count : 0;
		r.cmd = cmd_q;
		r.legacy = legacy;
		r.hasval = hasval;
		if (n == 0) begin
			r.cv = 1'b0;
			r.value = 8'h00;
			r.last = 1'b1;
			pending_results.insert(pending_results.size(), r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r.cv = 1'b1;
				r.value = value_buf[k];
				r.last = (k == n - 1);
				pending_results.insert(pending_results.size(), r);
			end
		end
	endfunction

	function automatic void legacy_byte(input logic [7:0] b);
		if (b == cfdd_pkg::CHAR_LF) begin
			if (second_seen && space_after_cmd && value_count > 0)
				queue_message(1'b1, 1'b1);
			go_hunting();
		end else if (!store_body(b)) begin
			go_hunting();
		end
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		bit keep;
		keep = 1'b1;
		case (parse_state)
			cfdd_pkg::MODE_HUNT: begin
				if (!(b inside {cfdd_pkg::CHAR_SP, cfdd_pkg::CHAR_TAB,
						cfdd_pkg::CHAR_CR, cfdd_pkg::CHAR_LF})) begin
					go_hunting();
					if (b == prefix_q) begin
						parse_state = cfdd_pkg::MODE_PREFIX1;
					end else begin
						parse_state = cfdd_pkg::MODE_LEGACY;
						cmd_q = b;
						cmd_seen = 1'b1;
					end
				end
			end
			cfdd_pkg::MODE_PREFIX1: begin
				if (b == prefix_q) begin
					if (prefix_q == term_q) begin
						go_hunting();
					end else begin
						parse_state = cfdd_pkg::MODE_FRAME;
						cmd_seen = 1'b0;
					end
				end else begin
					parse_state = cfdd_pkg::MODE_LEGACY;
					cmd_q = prefix_q;
					cmd_seen = 1'b1;
					legacy_byte(b);
				end
			end
			cfdd_pkg::MODE_LEGACY: begin
				legacy_byte(b);
			end
			default: begin
				if (term_held) begin
					if (b == term_q) begin
						if (cmd_seen)
							queue_message(1'b0, second_seen && space_after_cmd);
						go_hunting();
						keep = 1'b0;
					end else begin
						term_held = 1'b0;
						if (!store_body(term_q)) begin
							go_hunting();
							keep = 1'b0;
						end
					end
				end
				if (keep) begin
					if (b == term_q)
						term_held = 1'b1;
					else if (!store_body(b))
						go_hunting();
				end
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(15))
			0: return prefix_q;
			1: return term_q;
			2: return cfdd_pkg::CHAR_SP;
			3: return cfdd_pkg::CHAR_CR;
			4: return cfdd_pkg::CHAR_LF;
			5: return cfdd_pkg::CHAR_TAB;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (stall_en && $urandom_range(99) < IDLE_PCT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		deframe_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_frame(input logic [7:0] cmd, input bit spaced, input int vlen);
		send_byte(prefix_q);
		send_byte(prefix_q);
		send_byte(cmd);
		if (spaced)
			send_byte(cfdd_pkg::CHAR_SP);
		for (int i = 0; i < vlen; i++)
			send_byte(rand_byte());
		send_byte(term_q);
		send_byte(term_q);
	endtask

	task automatic send_legacy(input logic [7:0] cmd, input bit spaced, input int vlen);
		send_byte(cmd);
		send_byte(spaced ? cfdd_pkg::CHAR_SP : rand_byte());
		for (int i = 0; i < vlen; i++)
			send_byte(($urandom_range(7) == 0) ? rand_byte() : 8'($urandom_range(255)));
		send_byte(cfdd_pkg::CHAR_LF);
	endtask

	task automatic send_random_message(input bit allow_long);
		int kind;
		int vlen;
		kind = $urandom_range(99);
		if (allow_long && $urandom_range(19) == 0)
			vlen = $urandom_range(cfdd_pkg::VALUE_DEPTH + 2, cfdd_pkg::VALUE_DEPTH - 2);
		else
			vlen = $urandom_range(6);
		if (kind < 50) begin
			send_frame(rand_byte(), $urandom_range(4) != 0, vlen);
		end else if (kind < 80) begin
			send_legacy(8'($urandom_range(255)), $urandom_range(9) != 0, vlen);
		end else if (kind < 90) begin
			send_byte(prefix_q);
			send_byte(prefix_q);
			send_byte(8'($urandom_range(255)));
			for (int i = 0; i < vlen; i++)
				send_byte(rand_byte());
		end else begin
			repeat ($urandom_range(6, 1))
				send_byte(rand_byte());
		end
	endtask

	task automatic wait_drained();
		push = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_delimiters(input logic [7:0] p, input logic [7:0] t);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_write = 1'b1;
		cfg_index = cfdd_pkg::REG_PREFIX;
		cfg_data = p;
		@(negedge clk);
		prefix_q = p;
		cfg_index = cfdd_pkg::REG_TERM;
		cfg_data = t;
		@(negedge clk);
		term_q = t;
		cfg_write = 1'b0;
		settings_used++;
	endtask

	task automatic test_directed();
		send_text("&&A ");
		send_byte(8'h00);
		send_text("%b");
		send_byte(8'hff);
		send_text("%%");
		send_text("&&B%%");
		send_text(" \t\r\n& 1\n");
		send_text("&&C %%");
	endtask

	task automatic test_value_overflow();
		send_frame(8'h4f, 1'b1, cfdd_pkg::VALUE_DEPTH);
		send_frame(8'h50, 1'b1, cfdd_pkg::VALUE_DEPTH + 1);
		send_legacy(8'h51, 1'b1, cfdd_pkg::VALUE_DEPTH + 1);
	endtask

	task automatic test_random_stream();
		int target;
		int msgs;
		target = bytes_sent + 90;
		msgs = 0;
		while (bytes_sent < target) begin
			send_random_message(1'b1);
			msgs++;
			if (msgs == 10 || $urandom_range(24) == 0)
				wait_drained();
		end
	endtask

	task automatic test_back_to_back();
		int target;
		target = bytes_sent + 60;
		stall_en = 1'b0;
		while (bytes_sent < target)
			send_random_message(1'b0);
		stall_en = 1'b1;
	endtask

	task automatic test_delimiter_settings();
		logic [7:0] pfx [6];
		logic [7:0] trm [6];
		pfx = '{8'h00, 8'hff, 8'h5a, cfdd_pkg::CHAR_SP, 8'h23, cfdd_pkg::PREFIX_RESET};
		trm = '{8'hff, 8'h00, 8'h5a, 8'h25, cfdd_pkg::CHAR_LF, cfdd_pkg::TERM_RESET};
		for (int i = 0; i < 6; i++) begin
			set_delimiters(pfx[i], trm[i]);
			send_frame(8'h4b, 1'b1, 2);
			repeat (2)
				send_random_message(1'b0);
		end
	endtask

	always @(negedge clk)
		pop = arst_n && (!stall_en || $urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: command_char %0h value_char %0h",
					command_char, value_char);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (command_char !== want.cmd) begin
					$error("command_char: expected %0h, got %0h", want.cmd, command_char);
					errors++;
				end
				if (is_legacy !== want.legacy) begin
					$error("is_legacy: expected %0b, got %0b", want.legacy, is_legacy);
					errors++;
				end
				if (has_value !== want.hasval) begin
					$error("has_value: expected %0b, got %0b", want.hasval, has_value);
					errors++;
				end
				if (char_valid !== want.cv) begin
					$error("char_valid: expected %0b, got %0b", want.cv, char_valid);
					errors++;
				end
				if (value_char !== want.value) begin
					$error("value_char: expected %0h, got %0h", want.value, value_char);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					errors++;
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		cfg_write = 1'b0;
		cfg_index = cfdd_pkg::REG_PREFIX;
		cfg_data = '0;
		stall_en = 1'b1;
		errors = 0;
		bytes_sent = 0;
		results_seen = 0;
		settings_used = 0;
		idle_cycles = 0;
		reset_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_value_overflow();
		test_random_stream();
		test_back_to_back();
		test_delimiter_settings();

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d bytes under %0d delimiter settings, checked %0d results.",
			bytes_sent, settings_used + 1, results_seen);
		$display("Frames, legacy lines, lone delimiters, empty values and overflow exercised.");
		if (errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/cfdd_pkg.sv
rtl/cfdd_parser.sv
rtl/cfdd_msg_fifo.sv
rtl/cfdd_emitter.sv
rtl/command_frame_deframer_unit.sv
dv/tb_command_frame_deframer_unit.sv
